FILE: hdl/u2u8_pkg.sv
// Package with shared types and constants for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

	// Largest destination buffer size that the byte counter tracks.
	localparam int BUFFER_LIMIT = 4096;
	localparam int CNT_W        = $clog2(BUFFER_LIMIT + 1);

	// Configuration register fields.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP_ENABLE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 1'b1;
	localparam logic [CFG_DATA_W-1:0] BUFFER_BYTES_RESET = 13'd64;

	// Job queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// UTF-16 and UTF-8 constants.
	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [15:0] FIRST_PRINTABLE = 16'h0020;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [7:0]  LEAD2      = 8'hC0;
	localparam logic [7:0]  LEAD3      = 8'hE0;
	localparam logic [7:0]  LEAD4      = 8'hF0;
	localparam logic [7:0]  CONT       = 8'h80;

	// One queued job: the bytes of one character and an optional terminator.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            term;
	} job_t;

	// Push side of the queue.
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

endpackage

FILE: hdl/utf16_to_utf8_capped_transcoder_top.sv
// Top level of the UTF-16 to UTF-8 transcoder with an optional byte cap.
// Each code unit transaction is classified and encoded in the cycle it is accepted, and a
// new unit can be accepted every cycle while the four-entry job queue has room. The output
// side delivers one byte per cycle while out_ready is high; a unit yields zero to four
// bytes, plus one for the terminator on the final unit, and the byte-wide output register
// sets the sustained rate. Unpaired surrogates and code points below 0x20 produce no
// output. Configuration writes take effect from the next accepted unit and should be made
// while the block is idle.
module utf16_to_utf8_capped_transcoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      code_unit,
	input  logic                             last_unit,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic                             run_last,
	output logic                             string_end,
	input  logic                             cfg_we,
	input  logic [u2u8_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [u2u8_pkg::CFG_DATA_W-1:0]  cfg_data
);

	u2u8_pkg::push_t push;
	u2u8_pkg::job_t  head;
	logic            q_ready, head_valid, pop;

	u2u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_ready   (q_ready),
		.push      (push)
	);

	u2u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (q_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

FILE: hdl/u2u8_front.sv
// Front part: accepts code units, pairs surrogates, encodes and applies the cap.
module u2u8_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      code_unit,
	input  logic                             last_unit,
	input  logic                             cfg_we,
	input  logic [u2u8_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [u2u8_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             q_ready,
	output u2u8_pkg::push_t                  push
);

	logic                                cap_en_q;
	logic [u2u8_pkg::CFG_DATA_W-1:0]     buf_q;
	logic                                pend_q;
	logic [9:0]                          pend_hi_q;
	logic [u2u8_pkg::CNT_W-1:0]          bytes_q;
	logic                                cap_hit_q;

	logic                                is_high, is_low, pair, emit, refused, accept;
	logic [20:0]                         cp;
	logic [2:0]                          n, n_out;
	logic [3:0][7:0]                     b;
	logic [u2u8_pkg::CNT_W-1:0]          size, limit;
	logic [u2u8_pkg::CNT_W:0]            sum_n, sum_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q <= 1'b0;
			buf_q    <= u2u8_pkg::BUFFER_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				u2u8_pkg::CFG_CAP_ENABLE:   cap_en_q <= cfg_data[0];
				u2u8_pkg::CFG_BUFFER_BYTES: buf_q    <= cfg_data;
			endcase
		end
	end

	// Classify the unit and form the code point.
	always_comb begin
		is_high = (code_unit >= u2u8_pkg::HIGH_FIRST) && (code_unit <= u2u8_pkg::HIGH_LAST);
		is_low  = (code_unit >= u2u8_pkg::LOW_FIRST) && (code_unit <= u2u8_pkg::LOW_LAST);
		pair    = pend_q && is_low;
		emit    = pair || (!is_high && !is_low && (code_unit >= u2u8_pkg::FIRST_PRINTABLE));
		if (pair) begin
			cp = u2u8_pkg::SUPP_BASE + {1'b0, pend_hi_q, code_unit[9:0]};
		end else begin
			cp = {5'd0, code_unit};
		end
	end

	// UTF-8 encoding of the code point.
	always_comb begin
		b = '0;
		if (cp < 21'h80) begin
			b[0] = cp[7:0];
			n    = 3'd1;
		end else if (cp < 21'h800) begin
			b[0] = u2u8_pkg::LEAD2 | {3'd0, cp[10:6]};
			b[1] = u2u8_pkg::CONT | {2'd0, cp[5:0]};
			n    = 3'd2;
		end else if (cp < u2u8_pkg::SUPP_BASE) begin
			b[0] = u2u8_pkg::LEAD3 | {4'd0, cp[15:12]};
			b[1] = u2u8_pkg::CONT | {2'd0, cp[11:6]};
			b[2] = u2u8_pkg::CONT | {2'd0, cp[5:0]};
			n    = 3'd3;
		end else begin
			b[0] = u2u8_pkg::LEAD4 | {5'd0, cp[20:18]};
			b[1] = u2u8_pkg::CONT | {2'd0, cp[17:12]};
			b[2] = u2u8_pkg::CONT | {2'd0, cp[11:6]};
			b[3] = u2u8_pkg::CONT | {2'd0, cp[5:0]};
			n    = 3'd4;
		end
	end

	// Cap check against the clamped buffer size minus the terminator.
	always_comb begin
		if (32'(buf_q) > u2u8_pkg::BUFFER_LIMIT) begin
			size = u2u8_pkg::CNT_W'(u2u8_pkg::BUFFER_LIMIT);
		end else if (buf_q == '0) begin
			size = u2u8_pkg::CNT_W'(1);
		end else begin
			size = u2u8_pkg::CNT_W'(buf_q);
		end
		limit   = size - u2u8_pkg::CNT_W'(1);
		sum_n   = {1'b0, bytes_q} + (u2u8_pkg::CNT_W+1)'(n);
		refused = cap_en_q && (cap_hit_q || (sum_n > {1'b0, limit}));
		n_out   = (emit && !refused) ? n : 3'd0;
		sum_out = {1'b0, bytes_q} + (u2u8_pkg::CNT_W+1)'(n_out);
	end

	// Handshake and queue push.
	assign in_ready       = q_ready;
	assign accept         = in_valid && q_ready;
	assign push.valid     = accept && ((n_out != 3'd0) || last_unit);
	assign push.job.bytes = b;
	assign push.job.cnt   = n_out;
	assign push.job.term  = last_unit;

	// String state: held surrogate, byte count and cap flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			pend_hi_q <= '0;
			bytes_q   <= '0;
			cap_hit_q <= 1'b0;
		end else if (accept) begin
			if (last_unit) begin
				pend_q    <= 1'b0;
				pend_hi_q <= '0;
				bytes_q   <= '0;
				cap_hit_q <= 1'b0;
			end else begin
				pend_q <= !pair && is_high;
				if (!pair && is_high) begin
					pend_hi_q <= code_unit[9:0];
				end
				if (sum_out > (u2u8_pkg::CNT_W+1)'(u2u8_pkg::BUFFER_LIMIT)) begin
					bytes_q <= u2u8_pkg::CNT_W'(u2u8_pkg::BUFFER_LIMIT);
				end else begin
					bytes_q <= sum_out[u2u8_pkg::CNT_W-1:0];
				end
				if (emit && refused) begin
					cap_hit_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hdl/u2u8_queue.sv
// Short job queue that decouples the front from the back.
module u2u8_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  u2u8_pkg::push_t  push,
	output logic             push_ready,
	output logic             head_valid,
	output u2u8_pkg::job_t   head,
	input  logic             pop
);

	u2u8_pkg::job_t                 mem_q [u2u8_pkg::QUEUE_DEPTH];
	logic [u2u8_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [u2u8_pkg::QPTR_W:0]      count_q;
	logic                           do_push, do_pop;

	assign push_ready = count_q != (u2u8_pkg::QPTR_W+1)'(u2u8_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + u2u8_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + u2u8_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (u2u8_pkg::QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (u2u8_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: hdl/u2u8_back.sv
// Back part: serialises each queued job into output bytes through an output register.
module u2u8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  u2u8_pkg::job_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            string_end
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       load, is_last;

	assign total   = head.cnt + {2'd0, head.term};
	assign is_last = (idx_q + 3'd1) == total;
	assign load    = head_valid && (!out_valid || out_ready);
	assign pop     = load && is_last;

	// Byte position inside the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte   <= (idx_q < head.cnt) ? head.bytes[idx_q[1:0]] : 8'd0;
			string_end <= idx_q == head.cnt;
			run_last   <= is_last;
		end
	end

endmodule

FILE: test/utf16_to_utf8_capped_transcoder_top_tb.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder with an optional byte cap.
module utf16_to_utf8_capped_transcoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT       = 34;
	localparam int RANDOM_UNITS   = 195;
	localparam int PHASE_UNITS    = 24;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIR_N          = 25;

	// One output byte as the block should deliver it.
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       string_end;
	} utf8_beat_t;

	// One code unit to send; n_typed below zero leaves the bytes to the predictor.
	typedef struct {
		logic [15:0] cu;
		logic        last;
		int          n_typed;
		logic [7:0]  typed [5];
	} unit_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [15:0]                     code_unit = '0;
	logic                            last_unit = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [7:0]                      out_byte;
	logic                            run_last;
	logic                            string_end;
	logic                            cfg_we = 1'b0;
	logic [u2u8_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [u2u8_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	utf16_to_utf8_capped_transcoder_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_unit  (code_unit),
		.last_unit  (last_unit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Directed units: encoding boundaries, surrogate handling and terminators.
	unit_row_t dir_rows [DIR_N] = '{
		'{16'h0041, 1'b0,  1, '{8'h41, 0, 0, 0, 0}},
		'{16'h0000, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'h001F, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'h0020, 1'b0,  1, '{8'h20, 0, 0, 0, 0}},
		'{16'h007F, 1'b0,  1, '{8'h7F, 0, 0, 0, 0}},
		'{16'h0080, 1'b0,  2, '{8'hC2, 8'h80, 0, 0, 0}},
		'{16'h07FF, 1'b0,  2, '{8'hDF, 8'hBF, 0, 0, 0}},
		'{16'h0800, 1'b0,  3, '{8'hE0, 8'hA0, 8'h80, 0, 0}},
		'{16'hFFFF, 1'b0,  3, '{8'hEF, 8'hBF, 8'hBF, 0, 0}},
		'{16'hD800, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'hDC00, 1'b0,  4, '{8'hF0, 8'h90, 8'h80, 8'h80, 0}},
		'{16'hDBFF, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'hDFFF, 1'b0,  4, '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 0}},
		'{16'hD83D, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'h0042, 1'b0,  1, '{8'h42, 0, 0, 0, 0}},
		'{16'hDC00, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'hD800, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'hD801, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'hDE00, 1'b0, -1, '{0, 0, 0, 0, 0}},
		'{16'hDBFF, 1'b1,  1, '{8'h00, 0, 0, 0, 0}},
		'{16'hDC00, 1'b1,  1, '{8'h00, 0, 0, 0, 0}},
		'{16'h0000, 1'b1,  1, '{8'h00, 0, 0, 0, 0}},
		'{16'hFFFF, 1'b1,  4, '{8'hEF, 8'hBF, 8'hBF, 8'h00, 0}},
		'{16'hD800, 1'b0,  0, '{0, 0, 0, 0, 0}},
		'{16'hDC00, 1'b1,  5, '{8'hF0, 8'h90, 8'h80, 8'h80, 8'h00}}
	};

	utf8_beat_t expected_bytes [$];
	utf8_beat_t unit_beats [$];
	unit_row_t  string_units [$];
	int         mismatches = 0;
	int         units_sent = 0;
	int         idle_cycles = 0;
	bit         steady = 1'b0;

	// Transcoder state as the block should hold it.
	logic        cap_on = 1'b0;
	logic [12:0] buf_size = u2u8_pkg::BUFFER_BYTES_RESET;
	logic        held = 1'b0;
	logic [9:0]  held_bits = '0;
	int          byte_count = 0;
	logic        cap_hit = 1'b0;

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Encodes one code point, honouring the byte cap on whole characters.
	function automatic void encode_point(input int cp);
		logic [7:0] b [4];
		int         n;
		int         size;
		if (cp < 'h80) begin
			b[0] = 8'(cp);
			n = 1;
		end else if (cp < 'h800) begin
			b[0] = 8'(u2u8_pkg::LEAD2 | (cp >> 6));
			b[1] = 8'(u2u8_pkg::CONT | (cp & 'h3F));
			n = 2;
		end else if (cp < 'h10000) begin
			b[0] = 8'(u2u8_pkg::LEAD3 | (cp >> 12));
			b[1] = 8'(u2u8_pkg::CONT | ((cp >> 6) & 'h3F));
			b[2] = 8'(u2u8_pkg::CONT | (cp & 'h3F));
			n = 3;
		end else begin
			b[0] = 8'(u2u8_pkg::LEAD4 | ((cp >> 18) & 'h07));
			b[1] = 8'(u2u8_pkg::CONT | ((cp >> 12) & 'h3F));
			b[2] = 8'(u2u8_pkg::CONT | ((cp >> 6) & 'h3F));
			b[3] = 8'(u2u8_pkg::CONT | (cp & 'h3F));
			n = 4;
		end
		if (cap_on) begin
			size = int'(buf_size);
			if (size < 1) size = 1;
			if (size > u2u8_pkg::BUFFER_LIMIT) size = u2u8_pkg::BUFFER_LIMIT;
			if (cap_hit || byte_count + n > size - 1) begin
				cap_hit = 1'b1;
				return;
			end
		end
		for (int i = 0; i < n; i++)
			unit_beats.insert(unit_beats.size(), utf8_beat_t'{b[i], 1'b0, 1'b0});
		byte_count = byte_count + n;
		if (byte_count > u2u8_pkg::BUFFER_LIMIT) byte_count = u2u8_pkg::BUFFER_LIMIT;
	endfunction

	// Works out the bytes that one accepted code unit causes.
	function automatic void transcode_unit(input logic [15:0] cu, input logic last);
		logic is_high;
		logic is_low;
		unit_beats.delete();
		is_high = cu >= u2u8_pkg::HIGH_FIRST && cu <= u2u8_pkg::HIGH_LAST;
		is_low  = cu >= u2u8_pkg::LOW_FIRST && cu <= u2u8_pkg::LOW_LAST;
		if (held && is_low) begin
			held = 1'b0;
			encode_point(int'(u2u8_pkg::SUPP_BASE) + (int'(held_bits) << 10)
				+ int'(cu - u2u8_pkg::LOW_FIRST));
		end else begin
			held = 1'b0;
			if (is_high) begin
				if (!last) begin
					held = 1'b1;
					held_bits = 10'(cu - u2u8_pkg::HIGH_FIRST);
				end
			end else if (!is_low && cu >= u2u8_pkg::FIRST_PRINTABLE) begin
				encode_point(int'(cu));
			end
		end
		if (last) begin
			unit_beats.insert(unit_beats.size(), utf8_beat_t'{8'h00, 1'b0, 1'b1});
			held = 1'b0;
			held_bits = '0;
			byte_count = 0;
			cap_hit = 1'b0;
		end
		if (unit_beats.size() > 0) unit_beats[unit_beats.size() - 1].run_last = 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offers one code unit, with random idling beforehand, and records its bytes.
	task automatic send_unit(input unit_row_t row);
		steady = units_sent >= DIR_N + 70 && units_sent < DIR_N + 120;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		code_unit <= row.cu;
		last_unit <= row.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		transcode_unit(row.cu, row.last);
		if (row.n_typed < 0) begin
			foreach (unit_beats[i]) expected_bytes.insert(expected_bytes.size(), unit_beats[i]);
		end else begin
			for (int i = 0; i < row.n_typed; i++)
				expected_bytes.insert(expected_bytes.size(),
					utf8_beat_t'{row.typed[i], i == row.n_typed - 1,
					row.last && i == row.n_typed - 1});
		end
		units_sent++;
	endtask

	// Holds the sender back until every expected byte has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [u2u8_pkg::CFG_IDX_W-1:0] idx,
		input logic [u2u8_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == u2u8_pkg::CFG_CAP_ENABLE) cap_on = data[0];
		else buf_size = data;
		@(posedge clk);
	endtask

	// Picks the next register setting: the extremes first, then mostly small buffers.
	task automatic next_setting(input int phase);
		logic        cap;
		logic [12:0] size;
		case (phase)
			0: begin cap = 1'b1; size = 13'd1;    end
			1: begin cap = 1'b1; size = 13'd0;    end
			2: begin cap = 1'b1; size = 13'h1FFF; end
			3: begin cap = 1'b1; size = 13'd4096; end
			4: begin cap = 1'b1; size = 13'd2;    end
			5: begin cap = 1'b0; size = 13'd1;    end
			default: begin
				cap = $urandom_range(3) != 0;
				if ($urandom_range(9) == 0) size = 13'($urandom_range(8191));
				else size = 13'($urandom_range(16, 1));
			end
		endcase
		drain();
		write_reg(u2u8_pkg::CFG_CAP_ENABLE, u2u8_pkg::CFG_DATA_W'(cap));
		write_reg(u2u8_pkg::CFG_BUFFER_BYTES, size);
	endtask

	function automatic void add_unit(input logic [15:0] cu);
		string_units.insert(string_units.size(), unit_row_t'{cu, 1'b0, -1, '{default: 8'h00}});
	endfunction

	// Builds one string, mostly well-formed text with some malformed units mixed in.
	function automatic void build_string();
		int len;
		int kind;
		string_units.delete();
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
		for (int c = 0; c < len; c++) begin
			kind = $urandom_range(99);
			if (kind < 35) add_unit(16'($urandom_range('h7E, 'h20)));
			else if (kind < 50) add_unit(16'($urandom_range('h7FF, 'h80)));
			else if (kind < 62) begin
				if ($urandom_range(1)) add_unit(16'($urandom_range('hD7FF, 'h800)));
				else add_unit(16'($urandom_range('hFFFF, 'hE000)));
			end else if (kind < 80) begin
				add_unit(16'($urandom_range(u2u8_pkg::HIGH_LAST, u2u8_pkg::HIGH_FIRST)));
				add_unit(16'($urandom_range(u2u8_pkg::LOW_LAST, u2u8_pkg::LOW_FIRST)));
			end else if (kind < 86) add_unit(16'($urandom_range('h1F)));
			else if (kind < 90)
				add_unit(16'($urandom_range(u2u8_pkg::LOW_LAST, u2u8_pkg::LOW_FIRST)));
			else if (kind < 94)
				add_unit(16'($urandom_range(u2u8_pkg::HIGH_LAST, u2u8_pkg::HIGH_FIRST)));
			else add_unit(16'($urandom()));
		end
		string_units[string_units.size() - 1].last = 1'b1;
	endfunction

	// Output side stalls at random, except during the steady stretch.
	always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	// Each delivered byte is compared with the oldest expectation.
	always @(posedge clk) begin : check_output
		utf8_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %02h", $time, out_byte);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				check_field("out_byte", want.data, out_byte);
				check_field("run_last", 8'(want.run_last), 8'(run_last));
				check_field("string_end", 8'(want.string_end), 8'(string_end));
			end
		end
	end

	// Watchdog on cycles in which no transaction moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL utf16_to_utf8_capped_transcoder_top");
			$finish;
		end
	end

	// Reset, directed units, then random strings across several register settings.
	initial begin : stimulus
		int phase;
		int next_cfg_at;
		phase = 0;
		next_cfg_at = DIR_N;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i]) send_unit(dir_rows[i]);
		while (units_sent < DIR_N + RANDOM_UNITS) begin
			build_string();
			foreach (string_units[i]) begin
				// A setting may change mid-string; it applies from the next unit.
				if (units_sent >= next_cfg_at) begin
					next_setting(phase);
					phase++;
					next_cfg_at += PHASE_UNITS;
				end
				send_unit(string_units[i]);
			end
		end
		drain();
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("PASS utf16_to_utf8_capped_transcoder_top");
		end else begin
			$display("FAIL utf16_to_utf8_capped_transcoder_top");
		end
		$finish;
	end

endmodule
